// ===== rtl/core/toaq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package toaq_pkg;

	// Default sizes
	localparam int unsigned DEPTH_DEF        = 32;
	localparam int unsigned TIME_BITS_DEF    = 32;
	localparam int unsigned PAYLOAD_BITS_DEF = 32;

	// Width of every time and payload field on the ports
	localparam int unsigned FIELD_W = 32;

	// Command codes carried in s_tuser
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// Status codes carried in m_tuser
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_NA = 1'b1;

	// Per-cycle operation broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
	} toaq_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/toaq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module toaq_cell #(
	parameter int unsigned TIME_BITS    = 32,
	parameter int unsigned PAYLOAD_BITS = 32
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  toaq_pkg::toaq_ctrl_t    ctrl,
	input  wire [TIME_BITS-1:0]     new_time,
	input  wire [PAYLOAD_BITS-1:0]  new_payload,
	// neighbour towards the head
	input  wire                     left_keep,
	input  wire                     left_valid,
	input  wire [TIME_BITS-1:0]     left_time,
	input  wire [PAYLOAD_BITS-1:0]  left_payload,
	// neighbour towards the tail
	input  wire                     right_valid,
	input  wire [TIME_BITS-1:0]     right_time,
	input  wire [PAYLOAD_BITS-1:0]  right_payload,
	// own contents
	output logic                    keep,
	output logic                    valid,
	output logic [TIME_BITS-1:0]    time_val,
	output logic [PAYLOAD_BITS-1:0] payload
);
	import toaq_pkg::*;

	logic                    valid_q;
	logic [TIME_BITS-1:0]    time_q;
	logic [PAYLOAD_BITS-1:0] payload_q;

	// Entry stays put on push when it is due no later than the new one
	assign keep     = valid_q && (time_q <= new_time);
	assign valid    = valid_q;
	assign time_val = time_q;
	assign payload  = payload_q;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.push && !keep) begin
			valid_q <= left_keep ? 1'b1 : left_valid;
		end else if (ctrl.pop) begin
			valid_q <= right_valid;
		end
	end

	// Contents: insert, shift towards tail on push, towards head on pop
	always_ff @(posedge clk) begin
		if (ctrl.push && !keep) begin
			if (left_keep) begin
				time_q    <= new_time;
				payload_q <= new_payload;
			end else begin
				time_q    <= left_time;
				payload_q <= left_payload;
			end
		end else if (ctrl.pop) begin
			time_q    <= right_time;
			payload_q <= right_payload;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/time_ordered_activity_queue_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Time-ordered activity queue. Holds up to DEPTH activities (release time plus
// payload) sorted by time in a row of cells, earliest at cell 0; equal times
// leave in arrival order. Command in s_tuser: push inserts the activity (status
// not available when full), pop releases the head only if its time is not after
// the present time carried with the pop, and also reports the earliest time still
// pending. Every input transfer gives exactly one result transfer. All cells compare
// against the new time in parallel and shift in the same cycle, so a transfer can be
// accepted every cycle and its result appears in the output register on the next
// one; the output register stalls the input only while a result waits on m_tready.
module time_ordered_activity_queue_unit #(
	parameter int unsigned DEPTH        = toaq_pkg::DEPTH_DEF,
	parameter int unsigned TIME_BITS    = toaq_pkg::TIME_BITS_DEF,
	parameter int unsigned PAYLOAD_BITS = toaq_pkg::PAYLOAD_BITS_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [95:0]  s_tdata,  // new_time[31:0], new_payload[63:32], now_time[95:64]
	input  wire          s_tuser,  // command
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [103:0] m_tdata,  // out_time[31:0], out_payload[63:32], next_valid[64],
	                               // next_time[96:65], zero[103:97]
	output logic         m_tuser   // status
);
	import toaq_pkg::*;

	localparam int unsigned CMP_W = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;

	toaq_ctrl_t ctrl;

	logic [DEPTH-1:0]        valid_c;
	logic [DEPTH-1:0]        keep_c;
	logic [TIME_BITS-1:0]    time_c    [DEPTH];
	logic [PAYLOAD_BITS-1:0] payload_c [DEPTH];

	logic                    in_xfer;
	logic [TIME_BITS-1:0]    new_time;
	logic [PAYLOAD_BITS-1:0] new_payload;
	logic [FIELD_W-1:0]      cur_time;
	logic                    full;
	logic                    due;

	logic                    res_status;
	logic [FIELD_W-1:0]      res_time;
	logic [FIELD_W-1:0]      res_payload;
	logic                    res_next_valid;
	logic [FIELD_W-1:0]      res_next_time;

	logic                    out_valid_q;
	logic                    out_status_q;
	logic [FIELD_W-1:0]      out_time_q;
	logic [FIELD_W-1:0]      out_payload_q;
	logic                    out_next_valid_q;
	logic [FIELD_W-1:0]      out_next_time_q;

	// Input unpacking
	assign new_time    = TIME_BITS'(s_tdata[31:0]);
	assign new_payload = PAYLOAD_BITS'(s_tdata[63:32]);
	assign cur_time    = s_tdata[95:64];

	assign s_tready = !out_valid_q || m_tready;
	assign in_xfer  = s_tvalid && s_tready;

	assign full = valid_c[DEPTH-1];
	assign due  = valid_c[0] && (CMP_W'(time_c[0]) <= CMP_W'(cur_time));

	assign ctrl.push = in_xfer && (s_tuser == CMD_PUSH) && !full;
	assign ctrl.pop  = in_xfer && (s_tuser == CMD_POP) && due;

	// Row of cells, head at index 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                    l_keep;
		logic                    l_valid;
		logic [TIME_BITS-1:0]    l_time;
		logic [PAYLOAD_BITS-1:0] l_payload;
		logic                    r_valid;
		logic [TIME_BITS-1:0]    r_time;
		logic [PAYLOAD_BITS-1:0] r_payload;

		if (i == 0) begin : g_head
			assign l_keep    = 1'b1;
			assign l_valid   = 1'b0;
			assign l_time    = '0;
			assign l_payload = '0;
		end else begin : g_mid
			assign l_keep    = keep_c[i-1];
			assign l_valid   = valid_c[i-1];
			assign l_time    = time_c[i-1];
			assign l_payload = payload_c[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_valid   = 1'b0;
			assign r_time    = '0;
			assign r_payload = '0;
		end else begin : g_body
			assign r_valid   = valid_c[i+1];
			assign r_time    = time_c[i+1];
			assign r_payload = payload_c[i+1];
		end

		toaq_cell #(
			.TIME_BITS    (TIME_BITS),
			.PAYLOAD_BITS (PAYLOAD_BITS)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctrl          (ctrl),
			.new_time      (new_time),
			.new_payload   (new_payload),
			.left_keep     (l_keep),
			.left_valid    (l_valid),
			.left_time     (l_time),
			.left_payload  (l_payload),
			.right_valid   (r_valid),
			.right_time    (r_time),
			.right_payload (r_payload),
			.keep          (keep_c[i]),
			.valid         (valid_c[i]),
			.time_val      (time_c[i]),
			.payload       (payload_c[i])
		);
	end

	// Result of the current transfer, taken from the head before it moves
	always_comb begin
		res_status     = STATUS_NA;
		res_time       = '0;
		res_payload    = '0;
		res_next_valid = 1'b0;
		res_next_time  = '0;
		unique case (s_tuser)
			CMD_PUSH: begin
				res_status = full ? STATUS_NA : STATUS_OK;
			end
			CMD_POP: begin
				if (due) begin
					res_status     = STATUS_OK;
					res_time       = FIELD_W'(time_c[0]);
					res_payload    = FIELD_W'(payload_c[0]);
					res_next_valid = valid_c[1];
					res_next_time  = valid_c[1] ? FIELD_W'(time_c[1]) : '0;
				end else if (valid_c[0]) begin
					res_next_valid = 1'b1;
					res_next_time  = FIELD_W'(time_c[0]);
				end
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_status_q     <= res_status;
			out_time_q       <= res_time;
			out_payload_q    <= res_payload;
			out_next_valid_q <= res_next_valid;
			out_next_time_q  <= res_next_time;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {7'd0, out_next_time_q, out_next_valid_q, out_payload_q, out_time_q};

endmodule

`default_nettype wire

// ===== rtl/core/toaq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module toaq_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         s_tvalid,
	input wire         s_tready,
	input wire [95:0]  s_tdata,
	input wire         s_tuser,
	input wire         m_tvalid,
	input wire         m_tready,
	input wire [103:0] m_tdata,
	input wire         m_tuser
);
	import toaq_pkg::*;

	// A held result stays unchanged until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Every input transfer yields a result on the next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("missing result after input transfer");

	// Input is only held off while a result waits
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

	// A released activity is never later than the one left at the head
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STATUS_OK) && m_tdata[64] |-> m_tdata[31:0] <= m_tdata[96:65])
		else $error("released activity out of time order");

	// A refused request never carries a released activity
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STATUS_NA) |-> m_tdata[63:0] == 64'd0)
		else $error("refused request carries data");

endmodule

bind time_ordered_activity_queue_unit toaq_checker u_toaq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
